// ===== design/perspective_floor_texel_fetch_defines.svh =====
// Assertion macros for the checker file of the floor texel fetch block
`ifndef PERSPECTIVE_FLOOR_TEXEL_FETCH_DEFINES_SVH
`define PERSPECTIVE_FLOOR_TEXEL_FETCH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset
`define PFT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pft assertion failed");

// Next-cycle implication, sampled on the rising clock, off while in reset
`define PFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pft assertion failed");

`endif

// ===== design/pft_pkg.sv =====
// Types, constants and the sine table of the floor texel fetch block
package pft_pkg;

  localparam int TEX_SIDE      = 64;
  localparam int TEX_BITS      = $clog2(TEX_SIDE);
  localparam int TEX_CELLS     = TEX_SIDE * TEX_SIDE;
  localparam int ADDR_W        = 2 * TEX_BITS;
  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int HALF_W        = SCREEN_WIDTH / 2;
  localparam int TRIG_DEPTH    = 1024;
  localparam int TRIG_BITS     = $clog2(TRIG_DEPTH);
  localparam int TRIG_QUARTER  = TRIG_DEPTH / 4;
  localparam int QIDX_W        = TRIG_BITS - 1;

  localparam int FRAC_W        = 14;
  localparam int MOD_W         = TEX_BITS + FRAC_W;
  localparam int POLY_A        = 25736;
  localparam int POLY_B        = 10512;
  localparam int POLY_C        = 1160;

  localparam int NUM_W         = 36;
  localparam int DEN_W         = 25;
  localparam int DIST_LO_W     = 18;
  localparam int DIST_HI_W     = NUM_W - DIST_LO_W;
  localparam int PROD_W        = DIST_LO_W + 1 + 16;
  localparam int SUM_W         = 54;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = FIFO_PTR_W + 1;

  localparam logic signed [23:0] POS_X_RST      = 24'sd5120;
  localparam logic signed [23:0] POS_Z_RST      = 24'sd5120;
  localparam logic        [23:0] EYE_RST        = 24'd2560;
  localparam logic signed [23:0] VIEW_TOP_RST   = 24'sd2304;
  localparam logic        [19:0] FOCAL_RST      = 20'd8192;
  localparam logic        [15:0] HEADING_RST    = 16'd0;
  localparam logic        [11:0] ANGLE_STEP_RST = 12'd64;
  localparam logic        [15:0] QUARTER_TURN   = 16'd16384;

  typedef enum logic [2:0] {
    CFG_POS_X      = 3'd0,
    CFG_POS_Z      = 3'd1,
    CFG_EYE_HEIGHT = 3'd2,
    CFG_VIEW_TOP   = 3'd3,
    CFG_FOCAL_DIST = 3'd4,
    CFG_HEADING    = 3'd5,
    CFG_ANGLE_STEP = 3'd6
  } pft_cfg_e;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_RENDER = 1'b1
  } pft_action_e;

  typedef struct packed {
    logic       action;
    logic [11:0] texel_index;
    logic [7:0] texel_red;
    logic [7:0] texel_green;
    logic [7:0] texel_blue;
    logic [7:0] column;
    logic [7:0] row;
  } pft_in_t;

  typedef struct packed {
    logic [7:0] pix_column;
    logic [7:0] pix_row;
    logic       drawn;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pft_out_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_z;
  } pft_pos_t;

  // Classified item, minus the division operands
  typedef struct packed {
    logic        action;
    logic [11:0] texel_index;
    logic [23:0] rgb;
    logic [7:0]  column;
    logic [7:0]  row;
    logic        drawn;
    logic [15:0] angle;
  } pft_meta_t;

  typedef struct packed {
    pft_meta_t          meta;
    logic [DEN_W-1:0]   den;
    logic [NUM_W-1:0]   num;
  } pft_item_t;

  typedef logic [14:0] pft_qtab_t [TRIG_QUARTER+1];

  // Quarter-wave sine, Q1.14, entry k at phase k/TRIG_DEPTH of a turn
  function automatic pft_qtab_t build_qsin();
    pft_qtab_t tab;
    longint t, t2, inner, mid, s;
    for (int k = 0; k <= TRIG_QUARTER; k++) begin
      t     = (longint'(k) << 16) / TRIG_DEPTH;
      t2    = (t * t) >> 14;
      inner = POLY_B - ((t2 * POLY_C) >> 14);
      mid   = POLY_A - ((t2 * inner) >> 14);
      s     = (t * mid) >> 14;
      tab[k] = 15'(s);
    end
    return tab;
  endfunction

  localparam pft_qtab_t QSIN = build_qsin();

  function automatic logic signed [15:0] pft_sin(input logic [15:0] angle);
    logic [TRIG_BITS-1:0] idx;
    logic [1:0]           quad;
    logic [QIDX_W-2:0]    j;
    logic [QIDX_W-1:0]    k;
    logic [14:0]          s;
    idx  = angle[15 -: TRIG_BITS];
    quad = idx[TRIG_BITS-1 -: 2];
    j    = idx[TRIG_BITS-3:0];
    k    = quad[0] ? (QIDX_W'(TRIG_QUARTER) - {1'b0, j}) : {1'b0, j};
    s    = QSIN[k];
    return quad[1] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

endpackage

// ===== design/pft_if.sv =====
// Valid/ready stream interfaces for the input items and the rendered pixels
interface pft_in_if import pft_pkg::*; ();
  logic    valid;
  logic    ready;
  pft_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pft_out_if import pft_pkg::*; ();
  logic     valid;
  logic     ready;
  pft_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/pft_front.sv =====
// Front end: configuration registers, input accept, horizon test and operand setup
module pft_front import pft_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [23:0]     cfg_wdata_i,
  pft_in_if.sink          in_if,
  output logic            item_valid_o,
  output pft_item_t       item_o,
  input  logic            item_ready_i,
  output pft_pos_t        pos_o
);

  logic signed [23:0] pos_x_q, pos_z_q, view_top_q;
  logic        [23:0] eye_q;
  logic        [19:0] focal_q;
  logic        [15:0] heading_q;
  logic        [11:0] step_q;

  logic       fv_q, fv_d;
  pft_item_t  item_q, item_d;
  logic       accept;

  logic signed [25:0] line;
  logic signed [25:0] den_full;
  logic        [43:0] prod;
  logic signed [10:0] offset;
  logic signed [23:0] turn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= POS_X_RST;
      pos_z_q    <= POS_Z_RST;
      eye_q      <= EYE_RST;
      view_top_q <= VIEW_TOP_RST;
      focal_q    <= FOCAL_RST;
      heading_q  <= HEADING_RST;
      step_q     <= ANGLE_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POS_X:      pos_x_q    <= cfg_wdata_i;
        CFG_POS_Z:      pos_z_q    <= cfg_wdata_i;
        CFG_EYE_HEIGHT: eye_q      <= cfg_wdata_i;
        CFG_VIEW_TOP:   view_top_q <= cfg_wdata_i;
        CFG_FOCAL_DIST: focal_q    <= cfg_wdata_i[19:0];
        CFG_HEADING:    heading_q  <= cfg_wdata_i[15:0];
        CFG_ANGLE_STEP: step_q     <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !fv_q || item_ready_i;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    line     = 26'(view_top_q) - $signed({2'b00, in_if.data.row, 8'b0});
    den_full = $signed({2'b00, eye_q}) - line;
    prod     = focal_q * eye_q;
    offset   = $signed({3'b000, in_if.data.column}) - $signed(11'(HALF_W));
    turn     = offset * $signed({1'b0, step_q});

    item_d.meta.action      = in_if.data.action;
    item_d.meta.texel_index = in_if.data.texel_index;
    item_d.meta.rgb         = {in_if.data.texel_red, in_if.data.texel_green,
                               in_if.data.texel_blue};
    item_d.meta.column      = in_if.data.column;
    item_d.meta.row         = in_if.data.row;
    item_d.meta.drawn       = $signed({2'b00, eye_q}) > line;
    item_d.meta.angle       = heading_q + turn[15:0];
    item_d.den              = den_full[DEN_W-1:0];
    // The 1/256 of the denominator is folded into the numerator
    item_d.num              = prod[43:8];
  end

  assign fv_d = accept || (fv_q && !item_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = fv_q;
  assign item_o       = item_q;
  assign pos_o.pos_x  = pos_x_q;
  assign pos_o.pos_z  = pos_z_q;

endmodule

// ===== design/pft_fifo.sv =====
// Short queue that decouples the front end from the divider and fetch back end
module pft_fifo import pft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  pft_item_t push_item_i,
  output logic      push_ready_o,
  input  logic      pop_i,
  output logic      pop_valid_o,
  output pft_item_t pop_item_o
);

  pft_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  push, pop;

  assign push_ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/pft_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, item tag carried along
module pft_div import pft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_valid_i,
  input  pft_item_t        in_item_i,
  output logic             out_valid_o,
  output pft_meta_t        out_meta_o,
  output logic [NUM_W-1:0] out_quo_o
);

  logic             v_q    [NUM_W];
  logic [DEN_W-1:0] rem_q  [NUM_W];
  logic [NUM_W-1:0] nq_q   [NUM_W];
  logic [DEN_W-1:0] den_q  [NUM_W];
  pft_meta_t        meta_q [NUM_W];

  logic             v_in    [NUM_W];
  logic [DEN_W-1:0] rem_in  [NUM_W];
  logic [NUM_W-1:0] nq_in   [NUM_W];
  logic [DEN_W-1:0] den_in  [NUM_W];
  pft_meta_t        meta_in [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in[k]    = in_valid_i;
      assign rem_in[k]  = '0;
      assign nq_in[k]   = in_item_i.num;
      assign den_in[k]  = in_item_i.den;
      assign meta_in[k] = in_item_i.meta;
    end else begin : g_next
      assign v_in[k]    = v_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign nq_in[k]   = nq_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign meta_in[k] = meta_q[k-1];
    end

    // Bring down the next numerator bit, shift the quotient bit in behind it
    assign trial = {rem_in[k], nq_in[k][NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in[k]};
    assign diff  = trial - {1'b0, den_in[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_q[k]   <= {nq_in[k][NUM_W-2:0], ge};
        den_q[k]  <= den_in[k];
        meta_q[k] <= meta_in[k];
      end
    end
  end

  assign out_valid_o = v_q[NUM_W-1];
  assign out_meta_o  = meta_q[NUM_W-1];
  assign out_quo_o   = nq_q[NUM_W-1];

endmodule

// ===== design/pft_back.sv =====
// Back end: ray trig, texture coordinates, texture memory and the output register
module pft_back import pft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             en_o,
  input  logic             in_valid_i,
  input  pft_meta_t        in_meta_i,
  input  logic [NUM_W-1:0] in_dist_i,
  input  pft_pos_t         pos_i,
  pft_out_if.source        out_if
);

  // Stage 1: sine and cosine of the ray, split distance
  logic                   s1_v_q;
  pft_meta_t              s1_meta_q;
  logic signed [15:0]     s1_cos_q, s1_sin_q;
  logic [NUM_W-1:0]       s1_dist_q;

  // Stage 2: partial products
  logic                   s2_v_q;
  pft_meta_t              s2_meta_q;
  logic signed [PROD_W-1:0] s2_xl_q, s2_xh_q, s2_zl_q, s2_zh_q;

  // Stage 3: Q.14 sums
  logic                   s3_v_q;
  pft_meta_t              s3_meta_q;
  logic signed [SUM_W-1:0] s3_sx_q, s3_sz_q;

  // Output stage
  logic                   o_v_q;
  logic [7:0]             o_col_q, o_row_q;
  logic                   o_drawn_q;
  logic [23:0]            rdata_q;

  logic [23:0]            tex_mem [TEX_CELLS];

  logic signed [DIST_LO_W:0] dist_lo, dist_hi;
  logic [MOD_W-1:0]       mag_x, mag_z;
  logic [ADDR_W-1:0]      raddr;
  logic                   wr_en;

  assign en_o = !o_v_q || out_if.ready;

  assign dist_lo = $signed({1'b0, s1_dist_q[DIST_LO_W-1:0]});
  assign dist_hi = $signed({1'b0, s1_dist_q[NUM_W-1:DIST_LO_W]});

  // Truncating remainder then magnitude: only the low bits of |sum| matter
  always_comb begin
    mag_x = s3_sx_q[SUM_W-1] ? -s3_sx_q[MOD_W-1:0] : s3_sx_q[MOD_W-1:0];
    mag_z = s3_sz_q[SUM_W-1] ? -s3_sz_q[MOD_W-1:0] : s3_sz_q[MOD_W-1:0];
    raddr = {mag_z[MOD_W-1:FRAC_W], mag_x[MOD_W-1:FRAC_W]};
  end

  assign wr_en = en_o && s3_v_q && (s3_meta_q.action == ACT_LOAD) &&
                 (32'(s3_meta_q.texel_index) < 32'(TEX_CELLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (en_o) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      o_v_q  <= s3_v_q && (s3_meta_q.action == ACT_RENDER);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      s1_meta_q <= in_meta_i;
      s1_dist_q <= in_dist_i;
      s1_cos_q  <= pft_sin(in_meta_i.angle + QUARTER_TURN);
      s1_sin_q  <= pft_sin(in_meta_i.angle);

      s2_meta_q <= s1_meta_q;
      s2_xl_q   <= dist_lo * s1_cos_q;
      s2_xh_q   <= dist_hi * s1_cos_q;
      s2_zl_q   <= dist_lo * s1_sin_q;
      s2_zh_q   <= dist_hi * s1_sin_q;

      s3_meta_q <= s2_meta_q;
      s3_sx_q   <= (SUM_W'(s2_xh_q) <<< DIST_LO_W) + SUM_W'(s2_xl_q)
                   + (SUM_W'(pos_i.pos_x) <<< 6);
      s3_sz_q   <= (SUM_W'(s2_zh_q) <<< DIST_LO_W) + SUM_W'(s2_zl_q)
                   + (SUM_W'(pos_i.pos_z) <<< 6);

      o_col_q   <= s3_meta_q.column;
      o_row_q   <= s3_meta_q.row;
      o_drawn_q <= s3_meta_q.drawn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tex_mem[s3_meta_q.texel_index[ADDR_W-1:0]] <= s3_meta_q.rgb;
    end
    if (en_o) begin
      rdata_q <= tex_mem[raddr];
    end
  end

  assign out_if.valid           = o_v_q;
  assign out_if.data.pix_column = o_col_q;
  assign out_if.data.pix_row    = o_row_q;
  assign out_if.data.drawn      = o_drawn_q;
  assign out_if.data.red        = o_drawn_q ? rdata_q[23:16] : 8'd0;
  assign out_if.data.green      = o_drawn_q ? rdata_q[15:8]  : 8'd0;
  assign out_if.data.blue       = o_drawn_q ? rdata_q[7:0]   : 8'd0;

endmodule

// ===== design/perspective_floor_texel_fetch.sv =====
// Path: front register, queue, divider, back-end trig, product and sum stages, output register.
// Throughput: one item per clock unless the output stalls; a load takes a slot and gives no result.
// The 36-stage divider (one quotient bit per stage) sets the latency.
// A four-entry queue after the front end keeps input flowing while the output stalls, until it fills.
// Reset: asynchronous, active low; clears control state and loads register defaults.
// The texture memory is not cleared; texels read back undefined until loaded.
module perspective_floor_texel_fetch import pft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  pft_in_if.sink      in_if,
  pft_out_if.source   out_if
);

  logic             fr_valid, fr_ready;
  pft_item_t        fr_item;
  pft_pos_t         pos;
  logic             q_valid;
  pft_item_t        q_item;
  logic             en;
  logic             dv_valid;
  pft_meta_t        dv_meta;
  logic [NUM_W-1:0] dv_quo;

  pft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .item_valid_o(fr_valid),
    .item_o      (fr_item),
    .item_ready_i(fr_ready),
    .pos_o       (pos)
  );

  pft_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_item_i (fr_item),
    .push_ready_o(fr_ready),
    .pop_i       (en),
    .pop_valid_o (q_valid),
    .pop_item_o  (q_item)
  );

  pft_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (q_valid),
    .in_item_i  (q_item),
    .out_valid_o(dv_valid),
    .out_meta_o (dv_meta),
    .out_quo_o  (dv_quo)
  );

  pft_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_o      (en),
    .in_valid_i(dv_valid),
    .in_meta_i (dv_meta),
    .in_dist_i (dv_quo),
    .pos_i     (pos),
    .out_if    (out_if)
  );

endmodule

// ===== design/pft_checker.sv =====
// Port-level checks for the floor texel fetch block and their bind
`include "perspective_floor_texel_fetch_defines.svh"

module pft_checker import pft_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input pft_out_t out_data_i
);

  `PFT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  `PFT_ASSERT_SAME(a_black, out_valid_i && !out_data_i.drawn, out_data_i.red == 8'd0 && out_data_i.green == 8'd0 && out_data_i.blue == 8'd0)
  `PFT_ASSERT_NEXT(a_backpressure, !in_ready_i && out_valid_i && !out_ready_i, !in_ready_i)

endmodule

bind perspective_floor_texel_fetch pft_checker u_pft_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_data_i (out_if.data)
);
